// File: rtl/rcm_pkg.sv
`default_nettype none

package rcm_pkg;

    localparam int AliveTicksW = 4;
    localparam int HoldTicksW  = 8;
    localparam int RepressW    = 5;
    localparam int PressCountW = 3;
    localparam int PowerTicksW = 6;
    localparam int ByteW       = 8;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam int ALIVE_PERIOD_DEF  = 10;
    localparam int HOLD_TICKS_DEF    = 160;
    localparam int REPRESS_TICKS_DEF = 16;
    localparam int POWER_TICKS_DEF   = 50;

    localparam logic [CFG_INDEX_W-1:0] CFG_LIB_KNOWN         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STABLE_CODE       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_START_SELECT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_SHOULDERS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_STICKS       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_UP           = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SNAPSHOT_ENABLE   = 3'd6;

    typedef struct packed {
        logic             lib_known;
        logic [ByteW-1:0] stable_code;
        logic [ByteW-1:0] code_start_select;
        logic [ByteW-1:0] code_shoulders;
        logic [ByteW-1:0] code_sticks;
        logic [ByteW-1:0] code_up;
        logic             snapshot_enable;
    } cfg_t;

    typedef struct packed {
        logic             power_pressed;
        logic [ByteW-1:0] buttons_second;
        logic [ByteW-1:0] buttons_first;
        logic [ByteW-1:0] pad_frame;
        logic [ByteW-1:0] pad_state;
        logic             pad_present;
    } item_t;

    typedef struct packed {
        logic             request_valid;
        logic [ByteW-1:0] request_code;
        logic             cancel_poweroff;
        logic             alive;
        logic             alive_valid;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/rcm_cfg.sv
`default_nettype none

module rcm_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rcm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rcm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rcm_pkg::cfg_t                       cfg
);
    import rcm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LIB_KNOWN:         cfg_next.lib_known         = cfg_data[0];
                CFG_STABLE_CODE:       cfg_next.stable_code       = cfg_data;
                CFG_CODE_START_SELECT: cfg_next.code_start_select = cfg_data;
                CFG_CODE_SHOULDERS:    cfg_next.code_shoulders    = cfg_data;
                CFG_CODE_STICKS:       cfg_next.code_sticks       = cfg_data;
                CFG_CODE_UP:           cfg_next.code_up           = cfg_data;
                CFG_SNAPSHOT_ENABLE:   cfg_next.snapshot_enable   = cfg_data[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lib_known         <= 1'b0;
            cfg_reg.stable_code       <= 8'd0;
            cfg_reg.code_start_select <= 8'd1;
            cfg_reg.code_shoulders    <= 8'd0;
            cfg_reg.code_sticks       <= 8'd2;
            cfg_reg.code_up           <= 8'd3;
            cfg_reg.snapshot_enable   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/rcm_core.sv
`default_nettype none

module rcm_core #(
    parameter int ALIVE_PERIOD  = rcm_pkg::ALIVE_PERIOD_DEF,
    parameter int HOLD_TICKS    = rcm_pkg::HOLD_TICKS_DEF,
    parameter int REPRESS_TICKS = rcm_pkg::REPRESS_TICKS_DEF,
    parameter int POWER_TICKS   = rcm_pkg::POWER_TICKS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  rcm_pkg::item_t       item,
    input  rcm_pkg::cfg_t        cfg,
    output rcm_pkg::result_t     result
);
    import rcm_pkg::*;

    localparam logic [AliveTicksW-1:0] AliveMax   = '1;
    localparam logic [HoldTicksW-1:0]  HoldMax    = '1;
    localparam logic [RepressW-1:0]    RepressMax = '1;
    localparam logic [PressCountW-1:0] PressMax   = '1;
    localparam logic [PowerTicksW-1:0] PowerMax   = '1;

    localparam logic [AliveTicksW-1:0] AlivePeriod  = AliveTicksW'(ALIVE_PERIOD);
    localparam logic [HoldTicksW-1:0]  HoldLimit    = HoldTicksW'(HOLD_TICKS);
    localparam logic [RepressW-1:0]    RepressLimit = RepressW'(REPRESS_TICKS);
    localparam logic [PowerTicksW-1:0] PowerLimit   = PowerTicksW'(POWER_TICKS);

    logic [AliveTicksW-1:0] alive_ticks_reg, alive_ticks_next;
    logic [ByteW-1:0]       last_frame_reg, last_frame_next;
    logic [HoldTicksW-1:0]  hold_ticks_reg, hold_ticks_next;
    logic [RepressW-1:0]    repress_reg, repress_next;
    logic [PressCountW-1:0] press_count_reg, press_count_next;
    logic [PowerTicksW-1:0] power_ticks_reg, power_ticks_next;
    logic [ByteW-1:0]       request_reg, request_next;

    logic                   stable;
    logic                   match;
    logic [RepressW-1:0]    repress_mid;

    always_comb
    begin
        alive_ticks_next = alive_ticks_reg;
        last_frame_next  = last_frame_reg;
        hold_ticks_next  = hold_ticks_reg;
        press_count_next = press_count_reg;
        power_ticks_next = power_ticks_reg;
        request_next     = request_reg;
        repress_mid      = repress_reg;
        repress_next     = repress_reg;
        result           = '0;

        stable = item.pad_present && cfg.lib_known && (item.pad_state == cfg.stable_code);
        match  = (item.buttons_second == cfg.code_start_select)
              || ((item.buttons_first == cfg.code_shoulders)
                  && (item.buttons_second == cfg.code_sticks))
              || ((item.buttons_second == cfg.code_up) && cfg.snapshot_enable);

        if (stable)
        begin
            if (alive_ticks_reg != AliveMax)
            begin
                alive_ticks_next = alive_ticks_reg + 1'b1;
            end
            if (alive_ticks_reg >= AlivePeriod)
            begin
                result.alive_valid = 1'b1;
                alive_ticks_next   = '0;
                if (item.pad_frame != last_frame_reg)
                begin
                    result.alive    = 1'b1;
                    last_frame_next = item.pad_frame;
                end
            end

            if (match)
            begin
                if ((hold_ticks_reg == '0) && (repress_reg != '0))
                begin
                    request_next = item.buttons_second;
                end
                else
                begin
                    if (repress_reg == '0)
                    begin
                        repress_mid = RepressW'(1);
                    end
                    if (hold_ticks_reg != HoldMax)
                    begin
                        hold_ticks_next = hold_ticks_reg + 1'b1;
                    end
                    if (hold_ticks_reg >= HoldLimit)
                    begin
                        request_next = item.buttons_second;
                    end
                end
            end
            else
            begin
                hold_ticks_next = '0;
            end
        end
        else if (!item.pad_present)
        begin
            hold_ticks_next = '0;
        end

        repress_next = repress_mid;
        if (repress_mid != '0)
        begin
            if (repress_mid != RepressMax)
            begin
                repress_next = repress_mid + 1'b1;
            end
            if (repress_mid >= RepressLimit)
            begin
                repress_next = '0;
            end
        end

        if (item.power_pressed && (press_count_reg != PressMax))
        begin
            press_count_next = press_count_reg + 1'b1;
        end

        if (press_count_next != '0)
        begin
            if (power_ticks_reg != PowerMax)
            begin
                power_ticks_next = power_ticks_reg + 1'b1;
            end
            if (power_ticks_reg >= PowerLimit)
            begin
                request_next = (press_count_next == PressCountW'(1)) ? cfg.code_sticks
                                                                    : cfg.code_start_select;
            end
        end

        result.cancel_poweroff = item.power_pressed;
        result.request_code    = request_next;
        result.request_valid   = (request_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_ticks_reg <= '0;
            last_frame_reg  <= '0;
            hold_ticks_reg  <= '0;
            repress_reg     <= '0;
            press_count_reg <= '0;
            power_ticks_reg <= '0;
            request_reg     <= '0;
        end
        else if (accept)
        begin
            alive_ticks_reg <= alive_ticks_next;
            last_frame_reg  <= last_frame_next;
            hold_ticks_reg  <= hold_ticks_next;
            repress_reg     <= repress_next;
            press_count_reg <= press_count_next;
            power_ticks_reg <= power_ticks_next;
            request_reg     <= request_next;
        end
    end

`ifndef SYNTHESIS
    a_alive_ticks_bound: assert property (@(posedge clk) disable iff (!rst_n)
        alive_ticks_reg <= AlivePeriod)
        else $error("alive tick counter ran past its period");

    a_press_needs_power: assert property (@(posedge clk) disable iff (!rst_n)
        (press_count_reg == '0) |-> (power_ticks_reg == '0))
        else $error("power window counted without a press");

    a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(request_reg) && $stable(hold_ticks_reg))
        else $error("state moved without an accepted item");
`endif

endmodule

`default_nettype wire

// File: rtl/rcm_outbuf.sv
`default_nettype none

module rcm_outbuf (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  rcm_pkg::result_t in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output rcm_pkg::result_t out_data
);
    import rcm_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg, main_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    push;
    logic    pop;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_data_next  = in_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

`ifndef SYNTHESIS
    a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage holds an item ahead of the output stage");

    a_fill_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (push && main_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("item lost while the output stage was stalled");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (main_valid_reg && !skid_valid_reg
                                     && (main_data_reg == $past(skid_data_reg))))
        else $error("skid item not moved into the output stage");
`endif

endmodule

`default_nettype wire

// File: rtl/reset_combo_monitor_core.sv
`default_nettype none

// Channel   Direction  tdata fields (lowest bit first)
// s_axis    in         pad_present, pad_state, pad_frame, buttons_first,
//                      buttons_second, power_pressed, zero fill to 40 bits
// m_axis    out        alive_valid, alive, cancel_poweroff, request_code,
//                      request_valid, zero fill to 16 bits
// cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// Each item is worked out in the cycle it is accepted and one item can be taken every cycle
// while the buffer's skid entry is empty. Results are presented from the buffer's output register.
// A two-entry output buffer lets one more item in while a result waits to be taken.
// Reset clears all counters, the latched request and the buffer, and loads the register defaults.

module reset_combo_monitor_core #(
    parameter int ALIVE_PERIOD  = rcm_pkg::ALIVE_PERIOD_DEF,
    parameter int HOLD_TICKS    = rcm_pkg::HOLD_TICKS_DEF,
    parameter int REPRESS_TICKS = rcm_pkg::REPRESS_TICKS_DEF,
    parameter int POWER_TICKS   = rcm_pkg::POWER_TICKS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // pad_present, pad_state, pad_frame, buttons_first, buttons_second, power_pressed
    input  wire logic [rcm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // alive_valid, alive, cancel_poweroff, request_code, request_valid
    output logic [rcm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [rcm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rcm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rcm_pkg::*;

    localparam int ItemW   = $bits(item_t);
    localparam int ResultW = $bits(result_t);

    cfg_t    cfg;
    item_t   item;
    result_t result;
    result_t out_result;
    logic    accept;

    assign item   = item_t'(s_axis_tdata[ItemW-1:0]);
    assign accept = s_axis_tvalid && s_axis_tready;

    rcm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rcm_core #(
        .ALIVE_PERIOD  (ALIVE_PERIOD),
        .HOLD_TICKS    (HOLD_TICKS),
        .REPRESS_TICKS (REPRESS_TICKS),
        .POWER_TICKS   (POWER_TICKS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    rcm_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-ResultW){1'b0}}, out_result};

endmodule

`default_nettype wire
